### rtl/core/ifmt_pkg.sv
package ifmt_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int FWIDTH_W = 7;
  localparam int CHAR_W   = 8;

  // ten bcd digits hold any 32-bit magnitude
  localparam int BCD_DIGITS = 10;
  localparam int DREG_W     = 4 * BCD_DIGITS;
  localparam int NDIG_W     = 6;
  localparam int BCNT_W     = $clog2(VALUE_W);

  localparam logic [KIND_W-1:0] KIND_UDEC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SDEC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HEX  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OCT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BIN  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PTR  = 3'd5;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [1:0] {
    DS_1,
    DS_3,
    DS_4
  } dsize_t;

  typedef struct packed {
    logic              load;
    logic              shift;
    logic [DREG_W-1:0] data;
    logic [NDIG_W-1:0] ndig;
    dsize_t            size;
  } dreg_ctl_t;

  typedef struct packed {
    logic [3:0]        top;
    logic [NDIG_W-1:0] ndig;
  } dreg_stat_t;

  typedef struct packed {
    logic neg;
    logic ptr;
    logic left;
    logic zero;
  } emit_cmd_t;

endpackage

### rtl/core/ifmt_in_if.sv
interface ifmt_in_if;
  import ifmt_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [VALUE_W-1:0]  value;
  logic [FWIDTH_W-1:0] width;
  logic                left_justify;
  logic                zero_fill;

  modport source (
    output valid, kind, value, width, left_justify, zero_fill,
    input  ready
  );

  modport sink (
    input  valid, kind, value, width, left_justify, zero_fill,
    output ready
  );
endinterface

### rtl/core/ifmt_out_if.sv
interface ifmt_out_if;
  import ifmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (
    output valid, character, last,
    input  ready
  );

  modport sink (
    input  valid, character, last,
    output ready
  );
endinterface

### rtl/core/ifmt_bcd.sv
module ifmt_bcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ifmt_pkg::VALUE_W-1:0]  mag,
  output logic [ifmt_pkg::DREG_W-1:0]   bcd,
  output logic                          done
);
  import ifmt_pkg::*;

  logic                busy;
  logic [BCNT_W-1:0]   cnt;
  logic [VALUE_W-1:0]  sh;
  logic [DREG_W-1:0]   adj;

  // add-3 correction on every digit before the next bit shifts in
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == BCNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      sh  <= {sh[VALUE_W-2:0], 1'b0};
      bcd <= {adj[DREG_W-2:0], sh[VALUE_W-1]};
    end
  end
endmodule

### rtl/core/ifmt_dreg.sv
module ifmt_dreg (
  input  logic                   clk,
  input  ifmt_pkg::dreg_ctl_t    ctl,
  output ifmt_pkg::dreg_stat_t   stat
);
  import ifmt_pkg::*;

  logic [DREG_W-1:0] dig;
  logic [NDIG_W-1:0] ndig;
  dsize_t            size;
  logic [DREG_W-1:0] dig_shifted;

  // digits are left aligned, the most significant one at the top
  always_comb begin
    case (size)
      DS_1: begin
        stat.top    = {3'b000, dig[DREG_W-1]};
        dig_shifted = {dig[DREG_W-2:0], 1'b0};
      end
      DS_3: begin
        stat.top    = {1'b0, dig[DREG_W-1 -: 3]};
        dig_shifted = {dig[DREG_W-4:0], 3'b000};
      end
      DS_4: begin
        stat.top    = dig[DREG_W-1 -: 4];
        dig_shifted = {dig[DREG_W-5:0], 4'b0000};
      end
      default: begin
        stat.top    = dig[DREG_W-1 -: 4];
        dig_shifted = {dig[DREG_W-5:0], 4'b0000};
      end
    endcase
    stat.ndig = ndig;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dig  <= ctl.data;
      ndig <= ctl.ndig;
      size <= ctl.size;
    end else if (ctl.shift) begin
      dig  <= dig_shifted;
      ndig <= ndig - 1'b1;
    end
  end
endmodule

### rtl/core/ifmt_emit.sv
module ifmt_emit #(
  parameter int PAD_W = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ifmt_pkg::emit_cmd_t   cmd,
  input  logic [PAD_W-1:0]      pad,
  input  ifmt_pkg::dreg_stat_t  dstat,
  output logic                  dig_shift,
  output logic                  done,
  ifmt_out_if.source            text
);
  import ifmt_pkg::*;

  typedef enum logic [6:0] {
    E_IDLE = 7'b0000001,
    E_PRE  = 7'b0000010,
    E_SIGN = 7'b0000100,
    E_PX0  = 7'b0001000,
    E_PXX  = 7'b0010000,
    E_DIG  = 7'b0100000,
    E_POST = 7'b1000000
  } phase_t;

  phase_t            phase, phase_next;
  emit_cmd_t         cmd_r;
  logic [PAD_W-1:0]  pad_cnt, pad_cnt_next;
  logic              fire;

  function automatic phase_t after_sign(input logic ptr);
    return ptr ? E_PX0 : E_DIG;
  endfunction

  assign fire       = text.valid && text.ready;
  assign done       = fire && text.last;
  assign text.valid = (phase != E_IDLE);

  always_comb begin
    phase_next   = phase;
    pad_cnt_next = pad_cnt;
    dig_shift    = 1'b0;
    if (start) begin
      pad_cnt_next = pad;
      if (!cmd.left && pad != '0) begin
        phase_next = E_PRE;
      end else if (cmd.neg) begin
        phase_next = E_SIGN;
      end else begin
        phase_next = after_sign(cmd.ptr);
      end
    end else if (fire) begin
      case (phase)
        E_PRE: begin
          pad_cnt_next = pad_cnt - 1'b1;
          if (pad_cnt == PAD_W'(1)) begin
            phase_next = cmd_r.neg ? E_SIGN : after_sign(cmd_r.ptr);
          end
        end
        E_SIGN: phase_next = after_sign(cmd_r.ptr);
        E_PX0:  phase_next = E_PXX;
        E_PXX:  phase_next = E_DIG;
        E_DIG: begin
          dig_shift = 1'b1;
          if (dstat.ndig == NDIG_W'(1)) begin
            phase_next = (cmd_r.left && pad_cnt != '0) ? E_POST : E_IDLE;
          end
        end
        E_POST: begin
          pad_cnt_next = pad_cnt - 1'b1;
          if (pad_cnt == PAD_W'(1)) begin
            phase_next = E_IDLE;
          end
        end
        default: phase_next = E_IDLE;
      endcase
    end
  end

  always_comb begin
    case (phase)
      E_PRE:   text.character = cmd_r.zero ? CH_ZERO : CH_SPACE;
      E_SIGN:  text.character = CH_MINUS;
      E_PX0:   text.character = CH_ZERO;
      E_PXX:   text.character = CH_X;
      E_DIG:   text.character = HEX_DIGITS[dstat.top];
      default: text.character = CH_SPACE;
    endcase
  end

  assign text.last = (phase == E_DIG && dstat.ndig == NDIG_W'(1)
                      && !(cmd_r.left && pad_cnt != '0))
                   || (phase == E_POST && pad_cnt == PAD_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= E_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    pad_cnt <= pad_cnt_next;
    if (start) begin
      cmd_r <= cmd;
    end
  end
endmodule

### rtl/core/integer_field_formatter.sv
// Formats one 32-bit integer per transaction as an ASCII field, one character per output
// transaction with last on the final one. A conversion is taken only while the block is idle.
// Decimal kinds (unsigned, signed and the unused codes) first run a bit-serial binary-to-BCD
// converter; hex, octal, binary and pointer load their digits straight from the value. Leading
// zero digits are then shifted out one per cycle (up to 9 for decimal, 7 for hex, 10 for octal,
// 31 for binary), and the field streams out at one character per cycle while the downstream
// side holds ready high, max(width capped at MAX_WIDTH, text length) characters.
module integer_field_formatter #(
  parameter int MAX_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  ifmt_in_if.sink   conv,
  ifmt_out_if.source text
);
  import ifmt_pkg::*;

  localparam int PAD_W = $clog2(MAX_WIDTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_NORM = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t             state, state_next;
  emit_cmd_t          cmd, cmd_next;
  logic [PAD_W-1:0]   wsat, wsat_in;
  logic               accept;
  logic               pow2;
  logic               neg_in;
  logic [VALUE_W-1:0] mag;
  logic               bcd_start;
  logic [DREG_W-1:0]  bcd;
  logic               bcd_done;
  dreg_ctl_t          dctl;
  dreg_stat_t         dstat;
  logic               emit_start;
  logic               emit_shift;
  logic               emit_done;
  logic               norm_more;
  logic [PAD_W-1:0]   len;
  logic [PAD_W-1:0]   pad;

  assign conv.ready = (state == S_IDLE);
  assign accept     = conv.valid && conv.ready;

  assign pow2   = conv.kind inside {KIND_HEX, KIND_OCT, KIND_BIN, KIND_PTR};
  assign neg_in = (conv.kind == KIND_SDEC) && conv.value[VALUE_W-1];
  assign mag    = neg_in ? (VALUE_W'(0) - conv.value) : conv.value;

  always_comb begin
    if (int'(conv.width) > MAX_WIDTH) begin
      wsat_in = PAD_W'(MAX_WIDTH);
    end else begin
      wsat_in = PAD_W'(conv.width);
    end
    cmd_next.neg  = neg_in;
    cmd_next.ptr  = (conv.kind == KIND_PTR);
    cmd_next.left = conv.left_justify;
    cmd_next.zero = conv.zero_fill;
  end

  assign bcd_start = accept && !pow2;

  // skip leading zeros but always keep one digit
  assign norm_more = (dstat.top == 4'd0) && (dstat.ndig > NDIG_W'(1));

  always_comb begin
    len = PAD_W'(dstat.ndig) + PAD_W'(cmd.neg) + (cmd.ptr ? PAD_W'(2) : PAD_W'(0));
    pad = (wsat > len) ? (wsat - len) : '0;
  end

  assign emit_start = (state == S_NORM) && !norm_more;

  always_comb begin
    dctl.load  = 1'b0;
    dctl.shift = emit_shift || ((state == S_NORM) && norm_more);
    dctl.data  = bcd;
    dctl.ndig  = NDIG_W'(BCD_DIGITS);
    dctl.size  = DS_4;
    if (accept && pow2) begin
      dctl.load = 1'b1;
      case (conv.kind)
        KIND_OCT: begin
          dctl.data = {1'b0, conv.value, 7'b0};
          dctl.ndig = NDIG_W'(11);
          dctl.size = DS_3;
        end
        KIND_BIN: begin
          dctl.data = {conv.value, 8'b0};
          dctl.ndig = NDIG_W'(VALUE_W);
          dctl.size = DS_1;
        end
        default: begin
          dctl.data = {conv.value, 8'b0};
          dctl.ndig = NDIG_W'(VALUE_W / 4);
          dctl.size = DS_4;
        end
      endcase
    end else if (state == S_CONV && bcd_done) begin
      dctl.load = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = pow2 ? S_NORM : S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (!norm_more) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= cmd_next;
      wsat <= wsat_in;
    end
  end

  ifmt_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .mag   (mag),
    .bcd   (bcd),
    .done  (bcd_done)
  );

  ifmt_dreg u_dreg (
    .clk  (clk),
    .ctl  (dctl),
    .stat (dstat)
  );

  ifmt_emit #(
    .PAD_W (PAD_W)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (emit_start),
    .cmd       (cmd),
    .pad       (pad),
    .dstat     (dstat),
    .dig_shift (emit_shift),
    .done      (emit_done),
    .text      (text)
  );

`ifndef SYNTHESIS
  a_valid_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    text.valid |-> state == S_EMIT)
    else $error("output valid outside emit state");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready && text.last |=> state == S_IDLE)
    else $error("block not idle after final character");

  a_digits_present: assert property (@(posedge clk) disable iff (rst)
    state == S_NORM |-> dstat.ndig != '0)
    else $error("digit register empty while formatting");

  a_bcd_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    bcd_done |-> state == S_CONV)
    else $error("bcd conversion finished outside conversion state");
`endif
endmodule

### tb/integer_field_formatter_tb.sv
`timescale 1ns / 100ps

module integer_field_formatter_tb;
  import ifmt_pkg::*;

  localparam int FIELD_MAX = 64;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int ITEMS_PER_PHASE = 86;

  // codes 6 and 7 are not assigned a conversion and fall back to unsigned decimal
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  localparam string DIGIT_TEXT = "0123456789abcdef";
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_X     = 8'h78;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } field_char_t;

  class field_text_predictor;
    field_char_t expected_chars[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // renders one conversion and queues every character of its field
    function void add_conversion(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                                 logic [FWIDTH_W-1:0] fwidth, logic left, logic zero);
      logic [CHAR_W-1:0] text_chars[$];
      logic [CHAR_W-1:0] digits[$];
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] rem;
      logic [CHAR_W-1:0] fill;
      logic negative;
      logic pointer;
      int field_w;
      int pad;
      int total;
      int k;
      field_char_t beat;

      mag = value;
      negative = 1'b0;
      pointer = 1'b0;
      case (kind)
        KIND_SDEC: begin
          base = 10;
          if (value[VALUE_W-1]) begin
            negative = 1'b1;
            mag = -value;
          end
        end
        KIND_HEX: base = 16;
        KIND_OCT: base = 8;
        KIND_BIN: base = 2;
        KIND_PTR: begin
          base = 16;
          pointer = 1'b1;
        end
        default: base = 10;
      endcase

      do begin
        rem = mag % base;
        digits.push_front(DIGIT_TEXT[rem[3:0]]);
        mag = mag / base;
      end while (mag != 0);

      if (negative) text_chars.push_back(ASCII_MINUS);
      if (pointer) begin
        text_chars.push_back(ASCII_ZERO);
        text_chars.push_back(ASCII_X);
      end
      foreach (digits[i]) text_chars.push_back(digits[i]);

      field_w = (fwidth > FIELD_MAX) ? FIELD_MAX : int'(fwidth);
      total = (field_w > text_chars.size()) ? field_w : text_chars.size();
      pad = total - text_chars.size();
      fill = (!left && zero) ? ASCII_ZERO : ASCII_SPACE;

      // padding goes ahead of sign and prefix when right-justified
      if (!left) for (int i = 0; i < pad; i++) text_chars.push_front(fill);
      else for (int i = 0; i < pad; i++) text_chars.push_back(ASCII_SPACE);

      k = 0;
      foreach (text_chars[i]) begin
        beat.character = text_chars[i];
        beat.last = (k == total - 1);
        expected_chars.push_back(beat);
        k++;
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] character, logic last);
      field_char_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected character transaction: character %h last %b", character, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (character !== want.character) begin
        $error("character: expected %h, got %h", want.character, character);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  bit clk;
  logic rst;

  ifmt_in_if  conv_if();
  ifmt_out_if text_if();

  integer_field_formatter #(
    .MAX_WIDTH(FIELD_MAX)
  ) dut (
    .clk (clk),
    .rst (rst),
    .conv(conv_if),
    .text(text_if)
  );

  field_text_predictor book;
  int send_idle_pct;
  int recv_idle_pct;
  int holdoff_requests;
  int unsigned cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_field_formatter_tb: FAIL");
      $finish;
    end
  end

  // transaction monitors, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (text_if.valid && text_if.ready) book.check_char(text_if.character, text_if.last);
      if (conv_if.valid && conv_if.ready)
        book.add_conversion(conv_if.kind, conv_if.value, conv_if.width,
                            conv_if.left_justify, conv_if.zero_fill);
    end
  end

  // receiver: random backpressure, plus a long hold-off on request
  initial begin
    int holdoff_served;
    int holdoff_left;
    holdoff_served = 0;
    holdoff_left = 0;
    text_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holdoff_left == 0 && holdoff_served != holdoff_requests) begin
        holdoff_served++;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        text_if.ready <= 1'b0;
        holdoff_left--;
      end else begin
        text_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_conversion(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                                 logic [FWIDTH_W-1:0] fwidth, logic left, logic zero);
    while ($urandom_range(99) < send_idle_pct) begin
      conv_if.valid <= 1'b0;
      @(negedge clk);
    end
    conv_if.valid <= 1'b1;
    conv_if.kind <= kind;
    conv_if.value <= value;
    conv_if.width <= fwidth;
    conv_if.left_justify <= left;
    conv_if.zero_fill <= zero;
    do @(posedge clk); while (!conv_if.ready);
    @(negedge clk);
  endtask

  task automatic send_random_conversion();
    logic [KIND_W-1:0] kind;
    logic [VALUE_W-1:0] value;
    logic [FWIDTH_W-1:0] fwidth;
    if ($urandom_range(15) == 0) kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
    else kind = KIND_W'($urandom_range(5));
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: value = 32'h0000_0000;
          1: value = 32'hffff_ffff;
          2: value = 32'h8000_0000;
          default: value = 32'h7fff_ffff;
        endcase
      end
      1, 2: value = $urandom;
      default: value = $urandom >> $urandom_range(31);
    endcase
    // mostly short fields, now and then up to and past the saturation point
    if ($urandom_range(9) == 0) fwidth = FWIDTH_W'($urandom_range(127));
    else fwidth = FWIDTH_W'($urandom_range(24));
    send_conversion(kind, value, fwidth, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin
    book = new();
    cycle_count = 0;
    send_idle_pct = 7;
    recv_idle_pct = 45;
    holdoff_requests = 0;
    rst = 1'b1;
    conv_if.valid = 1'b0;
    conv_if.kind = KIND_UDEC;
    conv_if.value = '0;
    conv_if.width = '0;
    conv_if.left_justify = 1'b0;
    conv_if.zero_fill = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_conversion(KIND_UDEC, 32'h0000_0000, 7'd0, 1'b0, 1'b0);
    send_conversion(KIND_UDEC, 32'hffff_ffff, 7'd0, 1'b0, 1'b0);
    send_conversion(KIND_SDEC, 32'h8000_0000, 7'd0, 1'b0, 1'b0);
    send_conversion(KIND_SDEC, 32'h7fff_ffff, 7'd12, 1'b0, 1'b1);
    // zero fill lands ahead of the minus sign
    send_conversion(KIND_SDEC, 32'hffff_ffff, 7'd6, 1'b0, 1'b1);
    send_conversion(KIND_SDEC, 32'hffff_fffb, 7'd8, 1'b1, 1'b1);
    send_conversion(KIND_SDEC, 32'h0000_0000, 7'd0, 1'b0, 1'b0);
    send_conversion(KIND_HEX, 32'hdead_beef, 7'd0, 1'b0, 1'b0);
    send_conversion(KIND_HEX, 32'h0000_0000, 7'd3, 1'b0, 1'b1);
    send_conversion(KIND_HEX, 32'hffff_ffff, 7'd127, 1'b1, 1'b1);
    send_conversion(KIND_OCT, 32'hffff_ffff, 7'd0, 1'b0, 1'b0);
    send_conversion(KIND_OCT, 32'h4000_0000, 7'd15, 1'b0, 1'b0);
    send_conversion(KIND_BIN, 32'hffff_ffff, 7'd0, 1'b0, 1'b0);
    send_conversion(KIND_BIN, 32'h8000_0000, 7'd40, 1'b1, 1'b0);
    send_conversion(KIND_BIN, 32'h0000_0001, 7'd64, 1'b0, 1'b1);
    send_conversion(KIND_PTR, 32'h0000_0000, 7'd0, 1'b0, 1'b0);
    send_conversion(KIND_PTR, 32'h0000_12ab, 7'd10, 1'b0, 1'b1);
    send_conversion(KIND_PTR, 32'hffff_ffff, 7'd127, 1'b0, 1'b0);
    send_conversion(KIND_UDEC, 32'd42, 7'd65, 1'b1, 1'b0);
    send_conversion(KIND_UDEC, 32'd7, 7'd1, 1'b0, 1'b1);
    send_conversion(KIND_SPARE6, 32'd1234, 7'd5, 1'b0, 1'b0);
    send_conversion(KIND_SPARE7, 32'hffff_ffff, 7'd3, 1'b0, 1'b1);

    repeat (ITEMS_PER_PHASE) send_random_conversion();

    send_idle_pct = 45;
    recv_idle_pct = 7;
    repeat (ITEMS_PER_PHASE) send_random_conversion();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver stall while conversions keep being offered
    holdoff_requests = holdoff_requests + 1;
    repeat (ITEMS_PER_PHASE) send_random_conversion();

    conv_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("integer_field_formatter_tb: PASS");
    end else begin
      $display("integer_field_formatter_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ifmt_pkg.sv
rtl/core/ifmt_in_if.sv
rtl/core/ifmt_out_if.sv
rtl/core/ifmt_bcd.sv
rtl/core/ifmt_dreg.sv
rtl/core/ifmt_emit.sv
rtl/core/integer_field_formatter.sv
tb/integer_field_formatter_tb.sv
